// ----- src/s2wp_pkg.sv -----
package s2wp_pkg;

	// item geometry
	localparam int NUM_SENSORS = 5;
	localparam int ADC_W       = 12;
	localparam int POS_W       = 16;
	localparam int HEAD_W      = 9;
	localparam int PT_W        = 17;
	localparam int DIST_W      = 11;
	localparam int SCALE_W     = 21;
	localparam int RW          = 13;   // robot-frame coordinate, signed
	localparam int OFF_W       = 16;   // rotated offset in mm, signed
	localparam int WORLD_W     = 18;   // pose plus offset before clamping
	localparam int QTR_DEG     = 90;
	localparam int IDX_W       = 7;

	// stream packing
	localparam int S_TDATA_W   = 104;
	localparam int M_TDATA_W   = 176;
	localparam int POS_X_LSB   = NUM_SENSORS * ADC_W;
	localparam int POS_Y_LSB   = POS_X_LSB + POS_W;
	localparam int HEAD_LSB    = POS_Y_LSB + POS_W;

	// configuration registers
	localparam int CFG_W       = 16;
	localparam int CFG_IDX_W   = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROOM_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ROOM_HEIGHT = 2'd2;
	localparam logic [ADC_W-1:0] THRESHOLD_RESET   = 12'd614;
	localparam logic [POS_W-1:0] ROOM_WIDTH_RESET  = 16'd2500;
	localparam logic [POS_W-1:0] ROOM_HEIGHT_RESET = 16'd2000;

	// pi in Q60 and one degree in Q60
	localparam logic [63:0] PI_Q60  = 64'h3243F6A8885A308D;
	localparam logic [63:0] DEG_Q60 = PI_Q60 / 180;

	// per-stage load enables shared by all lanes
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} pipe_en_t;

	// sin(k deg), k in 0..90, Taylor series in Q30, rounded to Q1.f
	function automatic logic [63:0] qsin_fix(input int unsigned k, input int unsigned f);
		logic [63:0] r;
		logic [63:0] sum;
		logic [63:0] term;
		logic [63:0] t;
		r = ((64'(k) * DEG_Q60) + (64'd1 << 29)) >> 30;
		sum = r;
		term = r;
		for (int n = 1; n <= 7; n++) begin
			t = (term * r) >> 30;
			t = (t * r) >> 30;
			case (n)
				1: term = t / 64'd6;
				2: term = t / 64'd20;
				3: term = t / 64'd42;
				4: term = t / 64'd72;
				5: term = t / 64'd110;
				6: term = t / 64'd156;
				default: term = t / 64'd210;
			endcase
			if ((n & 1) == 1)
				sum = sum - term;
			else
				sum = sum + term;
		end
		return (sum + (64'd1 << (29 - f))) >> (30 - f);
	endfunction

endpackage

// ----- src/s2wp_trig.sv -----
module s2wp_trig #(
	parameter int F = 16
) (
	input  logic                          clk,
	input  s2wp_pkg::pipe_en_t            en,
	input  logic [s2wp_pkg::HEAD_W-1:0]   heading,
	output logic signed [F+1:0]           sin_s3,
	output logic signed [F+1:0]           cos_s3
);
	import s2wp_pkg::*;

	typedef struct packed {
		logic             neg;
		logic [IDX_W-1:0] idx;
	} quad_t;

	// quarter-wave sine table, Q1.F
	logic [F:0] qtab [0:QTR_DEG];

	for (genvar k = 0; k <= QTR_DEG; k++) begin : g_tab
		localparam logic [63:0] V = qsin_fix(k, F);
		assign qtab[k] = V[F:0];
	end

	// fold an angle in 0..359 onto the quarter wave
	function automatic quad_t fold(input logic [HEAD_W-1:0] a);
		quad_t q;
		priority if (a <= 9'd90) begin
			q.neg = 1'b0;
			q.idx = IDX_W'(a);
		end else if (a <= 9'd180) begin
			q.neg = 1'b0;
			q.idx = IDX_W'(9'd180 - a);
		end else if (a <= 9'd270) begin
			q.neg = 1'b1;
			q.idx = IDX_W'(a - 9'd180);
		end else begin
			q.neg = 1'b1;
			q.idx = IDX_W'(9'd360 - a);
		end
		return q;
	endfunction

	logic [HEAD_W-1:0]   h_red;
	logic [HEAD_W:0]     hc_sum;
	logic [HEAD_W-1:0]   hc_red;
	quad_t               qs;
	quad_t               qc;
	logic signed [F+1:0] sin_mag;
	logic signed [F+1:0] cos_mag;
	logic signed [F+1:0] sin_c;
	logic signed [F+1:0] cos_c;
	logic signed [F+1:0] sin_s1, cos_s1, sin_s2, cos_s2;

	// heading wrap, cos as sin shifted by a quarter turn
	always_comb begin
		h_red   = (heading >= 9'd360) ? heading - 9'd360 : heading;
		hc_sum  = {1'b0, h_red} + 10'd90;
		hc_red  = (hc_sum >= 10'd360) ? HEAD_W'(hc_sum - 10'd360) : HEAD_W'(hc_sum);
		qs      = fold(h_red);
		qc      = fold(hc_red);
		sin_mag = $signed({1'b0, qtab[qs.idx]});
		cos_mag = $signed({1'b0, qtab[qc.idx]});
		sin_c   = qs.neg ? -sin_mag : sin_mag;
		cos_c   = qc.neg ? -cos_mag : cos_mag;
	end

	// carry sin/cos alongside the lanes up to the rotation stage
	always_ff @(posedge clk) begin
		if (en.s1) begin
			sin_s1 <= sin_c;
			cos_s1 <= cos_c;
		end
		if (en.s2) begin
			sin_s2 <= sin_s1;
			cos_s2 <= cos_s1;
		end
		if (en.s3) begin
			sin_s3 <= sin_s2;
			cos_s3 <= cos_s2;
		end
	end

endmodule

// ----- src/s2wp_lane.sv -----
module s2wp_lane #(
	parameter int LANE = 0,
	parameter int F    = 16
) (
	input  logic                                clk,
	input  s2wp_pkg::pipe_en_t                  en,
	input  logic [s2wp_pkg::ADC_W-1:0]          adc,
	input  logic [s2wp_pkg::ADC_W-1:0]          thr,
	input  logic signed [F+1:0]                 sin_s3,
	input  logic signed [F+1:0]                 cos_s3,
	output logic                                ok_s5,
	output logic signed [s2wp_pkg::OFF_W-1:0]   off_x_s5,
	output logic signed [s2wp_pkg::OFF_W-1:0]   off_y_s5
);
	import s2wp_pkg::*;

	localparam int MW  = DIST_W + 1;
	localparam int KW  = F + 1;
	localparam int PAW = MW + KW;
	localparam int PW  = RW + F + 2;
	localparam int SW  = PW + 1;

	// mounting coefficients of this lane
	localparam logic [63:0] KA64 = (LANE == 1) ? qsin_fix(41, F) :
	                               (LANE == 3) ? qsin_fix(45, F) : 64'd0;
	localparam logic [63:0] KB64 = (LANE == 1) ? qsin_fix(49, F) :
	                               (LANE == 2) ? qsin_fix(1, F)  :
	                               (LANE == 3) ? qsin_fix(45, F) : 64'd0;
	localparam logic [KW-1:0]  KA     = KA64[KW-1:0];
	localparam logic [KW-1:0]  KB     = KB64[KW-1:0];
	localparam logic [PAW-1:0] HALF_P = PAW'(64'd1 << (F - 1));
	localparam logic [SW-1:0]  HALF_S = SW'(64'd1 << (F - 1));

	// stage 1: echo test and distance in mm
	logic [SCALE_W-1:0] scaled;
	logic [DIST_W-1:0]  d_c;
	logic               ok_s1;
	logic [DIST_W-1:0]  d_s1;

	always_comb begin
		scaled = SCALE_W'(adc) * SCALE_W'(360) + SCALE_W'(512);
		d_c    = DIST_W'(scaled >> 10) + DIST_W'(40);
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			ok_s1 <= (adc < thr);
			d_s1  <= d_c;
		end
	end

	// stage 2: mounting products
	logic [MW-1:0]  m1_c;
	logic           ok_s2;
	logic [DIST_W-1:0] d_s2;
	logic [PAW-1:0] pa_s2, pb_s2;

	assign m1_c = (LANE == 2) ? MW'(d_s1) + MW'(76) : MW'(d_s1) + MW'(75);

	always_ff @(posedge clk) begin
		if (en.s2) begin
			ok_s2 <= ok_s1;
			d_s2  <= d_s1;
			pa_s2 <= PAW'(m1_c) * PAW'(KA);
			pb_s2 <= PAW'(m1_c) * PAW'(KB);
		end
	end

	// stage 3: robot-frame point
	logic [PAW-1:0]       ra, rb;
	logic [MW-1:0]        m2_c;
	logic signed [RW-1:0] near_c;
	logic signed [RW-1:0] rx_c, ry_c;
	logic                 ok_s3;
	logic signed [RW-1:0] rx_s3, ry_s3;

	always_comb begin
		ra     = (pa_s2 + HALF_P) >> F;
		rb     = (pb_s2 + HALF_P) >> F;
		m2_c   = (LANE == 2) ? MW'(d_s2) + MW'(76) : MW'(d_s2) + MW'(75);
		near_c = $signed(RW'(d_s2) + RW'(73));
		case (LANE)
			0: begin
				rx_c = $signed(RW'(108));
				ry_c = near_c;
			end
			1: begin
				rx_c = $signed(RW'(116) + RW'(ra));
				ry_c = $signed(RW'(rb));
			end
			2: begin
				rx_c = $signed(RW'(116) + RW'(m2_c));
				ry_c = $signed(RW'(rb));
			end
			3: begin
				rx_c = $signed(RW'(116) + RW'(ra));
				ry_c = -$signed(RW'(rb));
			end
			default: begin
				rx_c = $signed(RW'(108));
				ry_c = -near_c;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			ok_s3 <= ok_s2;
			rx_s3 <= rx_c;
			ry_s3 <= ry_c;
		end
	end

	// stage 4: rotation products
	logic                 ok_s4;
	logic signed [PW-1:0] xc_s4, ys_s4, xs_s4, yc_s4;

	always_ff @(posedge clk) begin
		if (en.s4) begin
			ok_s4 <= ok_s3;
			xc_s4 <= PW'(rx_s3) * PW'(cos_s3);
			ys_s4 <= PW'(ry_s3) * PW'(sin_s3);
			xs_s4 <= PW'(rx_s3) * PW'(sin_s3);
			yc_s4 <= PW'(ry_s3) * PW'(cos_s3);
		end
	end

	// stage 5: sums rounded half away from zero
	function automatic logic signed [OFF_W-1:0] rnd(input logic signed [SW-1:0] v);
		logic [SW-1:0]          mag;
		logic [SW-1:0]          q;
		logic signed [OFF_W-1:0] o;
		mag = v[SW-1] ? -v : v;
		q   = (mag + HALF_S) >> F;
		o   = $signed(OFF_W'(q));
		return v[SW-1] ? -o : o;
	endfunction

	logic signed [SW-1:0] sx_c, sy_c;

	always_comb begin
		sx_c = SW'(xc_s4) - SW'(ys_s4);
		sy_c = SW'(xs_s4) + SW'(yc_s4);
	end

	always_ff @(posedge clk) begin
		if (en.s5) begin
			ok_s5    <= ok_s4;
			off_x_s5 <= rnd(sx_c);
			off_y_s5 <= rnd(sy_c);
		end
	end

endmodule

// ----- src/sensor_to_world_points_top.sv -----
// Sensor samples to world points.
// Input stream: one transfer carries five range samples, the robot position
// and its heading. Output stream: one transfer per input with an (x, y) world
// point for each of the five sensors, (-1, -1) where a sample shows no echo.
// Configuration: write threshold, room width and room height through the
// cfg_wr_en / cfg_addr / cfg_wdata port while the stream is idle.
// The path holds 6 register stages: stages 1 to 5 and then the output register
// that drives tvalid and tdata.
// Throughput is one item per cycle unless the receiver stalls: five lanes run
// side by side, each with registered mounting and rotation multipliers, and
// the heading sine/cosine come from one shared quarter-wave table.
// Every stage has its own valid bit and moves whenever the stage after it is
// empty or moving, so bubbles close up and input is still taken while a
// finished result waits in the output register.
// When the receiver holds tready low the output register keeps its data and
// the pipeline fills up behind it; s_axis_tready falls once all stages hold
// items. Reset clears all valid bits and loads the register defaults
// (threshold 614, room 2500 x 2000 mm).
module sensor_to_world_points_top #(
	parameter int TRIG_FRAC_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// adc_0..adc_4, pos_x, pos_y, heading (low to high), zero padded
	input  logic [s2wp_pkg::S_TDATA_W-1:0]    s_axis_tdata,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// point_x0, point_y0, point_x1, ... point_y4 (low to high), zero padded
	output logic [s2wp_pkg::M_TDATA_W-1:0]    m_axis_tdata,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	input  logic                              cfg_wr_en,
	input  logic [s2wp_pkg::CFG_IDX_W-1:0]    cfg_addr,
	input  logic [s2wp_pkg::CFG_W-1:0]        cfg_wdata
);
	import s2wp_pkg::*;

	localparam int F = TRIG_FRAC_BITS;

	// configuration registers
	logic [ADC_W-1:0] thr_q;
	logic [POS_W-1:0] room_w_q, room_h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q    <= THRESHOLD_RESET;
			room_w_q <= ROOM_WIDTH_RESET;
			room_h_q <= ROOM_HEIGHT_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_addr)
				CFG_THRESHOLD:   thr_q    <= cfg_wdata[ADC_W-1:0];
				CFG_ROOM_WIDTH:  room_w_q <= cfg_wdata[POS_W-1:0];
				CFG_ROOM_HEIGHT: room_h_q <= cfg_wdata[POS_W-1:0];
				default: ;
			endcase
		end
	end

	// stage valids and load enables
	logic     v_s1, v_s2, v_s3, v_s4, v_s5;
	logic     out_valid_q;
	logic     en_out;
	pipe_en_t en;

	always_comb begin
		en_out = !out_valid_q || m_axis_tready;
		en.s5  = !v_s5 || en_out;
		en.s4  = !v_s4 || en.s5;
		en.s3  = !v_s3 || en.s4;
		en.s2  = !v_s2 || en.s3;
		en.s1  = !v_s1 || en.s2;
	end

	assign s_axis_tready = en.s1;
	assign m_axis_tvalid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en.s1) v_s1 <= s_axis_tvalid;
			if (en.s2) v_s2 <= v_s1;
			if (en.s3) v_s3 <= v_s2;
			if (en.s4) v_s4 <= v_s3;
			if (en.s5) v_s5 <= v_s4;
			if (en_out) out_valid_q <= v_s5;
		end
	end

	// pose travels beside the lanes
	logic [POS_W-1:0] px_s1, px_s2, px_s3, px_s4, px_s5;
	logic [POS_W-1:0] py_s1, py_s2, py_s3, py_s4, py_s5;

	always_ff @(posedge clk) begin
		if (en.s1) begin
			px_s1 <= s_axis_tdata[POS_X_LSB +: POS_W];
			py_s1 <= s_axis_tdata[POS_Y_LSB +: POS_W];
		end
		if (en.s2) begin
			px_s2 <= px_s1;
			py_s2 <= py_s1;
		end
		if (en.s3) begin
			px_s3 <= px_s2;
			py_s3 <= py_s2;
		end
		if (en.s4) begin
			px_s4 <= px_s3;
			py_s4 <= py_s3;
		end
		if (en.s5) begin
			px_s5 <= px_s4;
			py_s5 <= py_s4;
		end
	end

	// shared heading sine/cosine
	logic signed [F+1:0] sin_s3, cos_s3;

	s2wp_trig #(
		.F(F)
	) u_trig (
		.clk    (clk),
		.en     (en),
		.heading(s_axis_tdata[HEAD_LSB +: HEAD_W]),
		.sin_s3 (sin_s3),
		.cos_s3 (cos_s3)
	);

	// per-sensor lanes
	logic                    ok_s5    [NUM_SENSORS];
	logic signed [OFF_W-1:0] off_x_s5 [NUM_SENSORS];
	logic signed [OFF_W-1:0] off_y_s5 [NUM_SENSORS];

	for (genvar i = 0; i < NUM_SENSORS; i++) begin : g_lane
		s2wp_lane #(
			.LANE(i),
			.F   (F)
		) u_lane (
			.clk     (clk),
			.en      (en),
			.adc     (s_axis_tdata[i*ADC_W +: ADC_W]),
			.thr     (thr_q),
			.sin_s3  (sin_s3),
			.cos_s3  (cos_s3),
			.ok_s5   (ok_s5[i]),
			.off_x_s5(off_x_s5[i]),
			.off_y_s5(off_y_s5[i])
		);
	end

	// merge: add pose, clamp to the room, pack the result
	function automatic logic [PT_W-1:0] place(input logic [POS_W-1:0] pos,
	                                           input logic signed [OFF_W-1:0] off,
	                                           input logic [POS_W-1:0] top,
	                                           input logic ok);
		logic signed [WORLD_W-1:0] w;
		logic signed [WORLD_W-1:0] lim;
		logic [PT_W-1:0]           p;
		w   = $signed({2'b00, pos}) + WORLD_W'(off);
		lim = $signed({2'b00, top});
		priority if (!ok)
			p = {PT_W{1'b1}};
		else if (w < 0)
			p = '0;
		else if (w > lim)
			p = PT_W'(top);
		else
			p = PT_W'(w);
		return p;
	endfunction

	logic [M_TDATA_W-1:0] tdata_c;

	always_comb begin
		tdata_c = '0;
		for (int i = 0; i < NUM_SENSORS; i++) begin
			tdata_c[2*i*PT_W +: PT_W]     = place(px_s5, off_x_s5[i], room_w_q, ok_s5[i]);
			tdata_c[(2*i+1)*PT_W +: PT_W] = place(py_s5, off_y_s5[i], room_h_q, ok_s5[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en_out)
			m_axis_tdata <= tdata_c;
	end

endmodule

// ----- tb/tb.sv -----
module tb;

	localparam int FRAC        = 16;
	localparam int LATENCY     = 6;
	localparam int CYCLE_LIMIT = 600000;
	localparam int PTS_W       = 2 * s2wp_pkg::NUM_SENSORS * s2wp_pkg::PT_W;
	localparam int PHASE_ITEMS = 322;

	// register index that maps to no register
	localparam logic [s2wp_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	// sensor positions on the robot
	localparam int LEFT        = 0;
	localparam int LEFT_FRONT  = 1;
	localparam int FRONT       = 2;
	localparam int RIGHT_FRONT = 3;
	localparam int RIGHT       = 4;

	localparam logic [63:0] PI_Q60      = 64'h3243F6A8885A308D;
	localparam logic [63:0] ONE_DEG_Q60 = PI_Q60 / 180;
	localparam longint      HALF_LSB    = 1 << (FRAC - 1);
	localparam logic [s2wp_pkg::PT_W-1:0] NO_ECHO = '1;

	logic clk;
	logic arst_n = 1'b0;
	// adc_0..adc_4, pos_x, pos_y, heading (low to high), zero padded
	logic [s2wp_pkg::S_TDATA_W-1:0] s_axis_tdata = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	// point_x0, point_y0, point_x1, ... point_y4 (low to high), zero padded
	logic [s2wp_pkg::M_TDATA_W-1:0] m_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [s2wp_pkg::CFG_IDX_W-1:0] cfg_addr = '0;
	logic [s2wp_pkg::CFG_W-1:0] cfg_wdata = '0;

	// predictor copy of the registers
	logic [s2wp_pkg::ADC_W-1:0] echo_limit = s2wp_pkg::THRESHOLD_RESET;
	logic [s2wp_pkg::POS_W-1:0] room_x_max = s2wp_pkg::ROOM_WIDTH_RESET;
	logic [s2wp_pkg::POS_W-1:0] room_y_max = s2wp_pkg::ROOM_HEIGHT_RESET;

	logic [PTS_W-1:0] expected_points[$];
	int failures = 0;
	int burst_left = 0;
	int cycles = 0;

	sensor_to_world_points_top #(
		.TRIG_FRAC_BITS(FRAC)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.cfg_wr_en(cfg_wr_en),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// sin(k deg) for k in 0..90, Q1.FRAC, Taylor series summed in Q30
	function automatic longint quarter_wave_sin(input logic [63:0] k);
		logic [63:0] ang;
		logic [63:0] acc;
		logic [63:0] term;
		logic [63:0] prod;
		logic [63:0] div;
		int unsigned n;
		ang = ((k * ONE_DEG_Q60) + (64'd1 << 29)) >> 30;
		acc = ang;
		term = ang;
		for (n = 1; n <= 7; n++) begin
			prod = (term * ang) >> 30;
			prod = (prod * ang) >> 30;
			div = (2 * n) * (2 * n + 1);
			term = prod / div;
			if (n % 2 == 1)
				acc = acc - term;
			else
				acc = acc + term;
		end
		return (acc + (64'd1 << (29 - FRAC))) >> (30 - FRAC);
	endfunction

	// full-circle sine from quadrant symmetry, h in 0..359
	function automatic longint sin_deg(input int h);
		if (h <= 90)
			return quarter_wave_sin(64'(h));
		if (h <= 180)
			return quarter_wave_sin(64'(180 - h));
		if (h <= 270)
			return -quarter_wave_sin(64'(h - 180));
		return -quarter_wave_sin(64'(360 - h));
	endfunction

	// Q1.FRAC product to mm, half away from zero
	function automatic longint round_mm(input longint v);
		if (v >= 0)
			return (v + HALF_LSB) >>> FRAC;
		return -((-v + HALF_LSB) >>> FRAC);
	endfunction

	function automatic logic [s2wp_pkg::PT_W-1:0] clamp_coord(input longint v, input longint top);
		if (v < 0)
			return '0;
		if (v > top)
			return top[s2wp_pkg::PT_W-1:0];
		return v[s2wp_pkg::PT_W-1:0];
	endfunction

	// expected world points for one sample set under the current registers
	function automatic logic [PTS_W-1:0] world_points(input logic [s2wp_pkg::S_TDATA_W-1:0] item);
		logic [PTS_W-1:0] pts;
		logic [s2wp_pkg::ADC_W-1:0] s;
		longint d, rx, ry, wx, wy, ch, sh, px, py;
		longint sin_1, sin_41, sin_45, sin_49;
		int h;
		int i;
		pts = '0;
		px = item[s2wp_pkg::POS_X_LSB +: s2wp_pkg::POS_W];
		py = item[s2wp_pkg::POS_Y_LSB +: s2wp_pkg::POS_W];
		h = item[s2wp_pkg::HEAD_LSB +: s2wp_pkg::HEAD_W];
		if (h >= 360)
			h = h - 360;
		ch = sin_deg((h + 90) % 360);
		sh = sin_deg(h);
		sin_1 = quarter_wave_sin(1);
		sin_41 = quarter_wave_sin(41);
		sin_45 = quarter_wave_sin(45);
		sin_49 = quarter_wave_sin(49);
		for (i = 0; i < s2wp_pkg::NUM_SENSORS; i++) begin
			s = item[i * s2wp_pkg::ADC_W +: s2wp_pkg::ADC_W];
			if (s >= echo_limit) begin
				pts[(2 * i) * s2wp_pkg::PT_W +: s2wp_pkg::PT_W] = NO_ECHO;
				pts[(2 * i + 1) * s2wp_pkg::PT_W +: s2wp_pkg::PT_W] = NO_ECHO;
			end else begin
				d = ((360 * s + 512) >> 10) + 40;
				// robot-frame hit point from the mounting geometry
				case (i)
					LEFT: begin
						rx = 108;
						ry = d + 73;
					end
					LEFT_FRONT: begin
						rx = 116 + round_mm((d + 75) * sin_41);
						ry = round_mm((d + 75) * sin_49);
					end
					FRONT: begin
						rx = 116 + d + 76;
						ry = round_mm((d + 76) * sin_1);
					end
					RIGHT_FRONT: begin
						rx = 116 + round_mm((d + 75) * sin_45);
						ry = -round_mm((d + 75) * sin_45);
					end
					default: begin
						rx = 108;
						ry = -(d + 73);
					end
				endcase
				wx = px + round_mm(rx * ch - ry * sh);
				wy = py + round_mm(rx * sh + ry * ch);
				pts[(2 * i) * s2wp_pkg::PT_W +: s2wp_pkg::PT_W] = clamp_coord(wx, room_x_max);
				pts[(2 * i + 1) * s2wp_pkg::PT_W +: s2wp_pkg::PT_W] = clamp_coord(wy, room_y_max);
			end
		end
		return pts;
	endfunction

	// compare each output transfer with the oldest expected point set
	always @(posedge clk) begin : check_points
		logic [PTS_W-1:0] want;
		int k;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_points.size() == 0) begin
				failures++;
				$display("%0t: output transfer with nothing expected, actual %h",
					$time, m_axis_tdata[PTS_W-1:0]);
			end else begin
				want = expected_points.pop_front();
				for (k = 0; k < 2 * s2wp_pkg::NUM_SENSORS; k++) begin
					if (m_axis_tdata[k * s2wp_pkg::PT_W +: s2wp_pkg::PT_W]
							!== want[k * s2wp_pkg::PT_W +: s2wp_pkg::PT_W]) begin
						failures++;
						$display("%0t: sensor %0d %s expected %0d actual %0d", $time,
							k / 2, (k % 2) ? "y" : "x",
							$signed(want[k * s2wp_pkg::PT_W +: s2wp_pkg::PT_W]),
							$signed(m_axis_tdata[k * s2wp_pkg::PT_W +: s2wp_pkg::PT_W]));
					end
				end
			end
		end
	end

	// receiver backpressure in one of four randomly picked modes
	always @(posedge clk) begin : rx_stalls
		int rx_mode;
		int stall_left;
		int rx_cycle;
		logic ready_next;
		rx_cycle++;
		if (rx_cycle % 500 == 0)
			rx_mode = $urandom_range(0, 3);
		case (rx_mode)
			0: ready_next = 1'b1;
			1: ready_next = ($urandom_range(0, 3) != 0);
			2: ready_next = (rx_cycle % 4 == 0);
			default: begin
				if (stall_left > 0) begin
					stall_left--;
					ready_next = 1'b0;
				end else begin
					ready_next = 1'b1;
					if ($urandom_range(0, 5) == 0)
						stall_left = $urandom_range(1, 15);
				end
			end
		endcase
		m_axis_tready <= ready_next;
	end

	// sender bursts with random gaps
	task automatic pace_sender();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 4);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
				: $urandom_range(0, 12);
		end
	endtask

	task automatic send_sample_set(input logic [11:0] a0, a1, a2, a3, a4,
			input logic [15:0] x, y, input logic [8:0] hd);
		logic [s2wp_pkg::S_TDATA_W-1:0] item;
		item = '0;
		item[0 * s2wp_pkg::ADC_W +: s2wp_pkg::ADC_W] = a0;
		item[1 * s2wp_pkg::ADC_W +: s2wp_pkg::ADC_W] = a1;
		item[2 * s2wp_pkg::ADC_W +: s2wp_pkg::ADC_W] = a2;
		item[3 * s2wp_pkg::ADC_W +: s2wp_pkg::ADC_W] = a3;
		item[4 * s2wp_pkg::ADC_W +: s2wp_pkg::ADC_W] = a4;
		item[s2wp_pkg::POS_X_LSB +: s2wp_pkg::POS_W] = x;
		item[s2wp_pkg::POS_Y_LSB +: s2wp_pkg::POS_W] = y;
		item[s2wp_pkg::HEAD_LSB +: s2wp_pkg::HEAD_W] = hd;
		s_axis_tdata <= item;
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		expected_points.push_back(world_points(item));
		pace_sender();
	endtask

	// stop sending and let every pending point set come out
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (expected_points.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [s2wp_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] val);
		cfg_addr <= idx;
		cfg_wdata <= val;
		cfg_wr_en <= 1'b1;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			s2wp_pkg::CFG_THRESHOLD: echo_limit = val[s2wp_pkg::ADC_W-1:0];
			s2wp_pkg::CFG_ROOM_WIDTH: room_x_max = val;
			s2wp_pkg::CFG_ROOM_HEIGHT: room_y_max = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	function automatic logic [11:0] pick_sample();
		int unsigned sel;
		sel = $urandom_range(0, 7);
		if (sel < 3 || echo_limit == 0)
			return 12'($urandom_range(0, 4095));
		if (sel == 3)
			return 12'(echo_limit - 1 + $urandom_range(0, 1));
		return 12'($urandom_range(0, echo_limit - 1));
	endfunction

	function automatic logic [15:0] pick_coord(input logic [15:0] top);
		if ($urandom_range(0, 4) == 0)
			return 16'($urandom_range(0, 65535));
		return 16'($urandom_range(0, top));
	endfunction

	function automatic logic [8:0] pick_heading();
		if ($urandom_range(0, 6) == 0)
			return 9'($urandom_range(360, 511));
		return 9'($urandom_range(0, 359));
	endfunction

	// reset registers: validity edge, every quadrant, heading wrap, clamping
	task automatic test_default_geometry();
		send_sample_set(0, 0, 0, 0, 0, 1000, 1000, 0);
		send_sample_set(4095, 4095, 4095, 4095, 4095, 1000, 1000, 0);
		send_sample_set(613, 614, 612, 615, 1, 1200, 900, 90);
		send_sample_set(0, 100, 200, 300, 400, 1250, 1000, 180);
		send_sample_set(500, 450, 350, 250, 150, 1250, 1000, 270);
		send_sample_set(100, 100, 100, 100, 100, 1250, 1000, 359);
		send_sample_set(100, 200, 300, 400, 500, 1250, 1000, 360);
		send_sample_set(100, 200, 300, 400, 500, 1250, 1000, 361);
		send_sample_set(100, 200, 300, 400, 500, 1250, 1000, 511);
		send_sample_set(600, 600, 600, 600, 600, 0, 0, 45);
		send_sample_set(600, 600, 600, 600, 600, 65535, 65535, 135);
		send_sample_set(0, 0, 0, 0, 0, 2500, 2000, 225);
		send_sample_set(300, 300, 300, 300, 300, 1500, 700, 315);
	endtask

	// register extremes, unused index, masking of threshold
	task automatic test_register_extremes();
		wait_drained();
		write_reg(s2wp_pkg::CFG_THRESHOLD, 16'd0);
		send_sample_set(0, 0, 0, 0, 0, 1000, 1000, 0);
		wait_drained();
		write_reg(s2wp_pkg::CFG_THRESHOLD, 16'd4095);
		write_reg(s2wp_pkg::CFG_ROOM_WIDTH, 16'd65535);
		write_reg(s2wp_pkg::CFG_ROOM_HEIGHT, 16'd65535);
		send_sample_set(4094, 4095, 0, 4094, 2048, 65535, 65535, 0);
		send_sample_set(0, 4094, 0, 0, 4094, 0, 0, 180);
		send_sample_set(4094, 4094, 4094, 4094, 4094, 32768, 32768, 45);
		wait_drained();
		write_reg(s2wp_pkg::CFG_ROOM_WIDTH, 16'd0);
		write_reg(s2wp_pkg::CFG_ROOM_HEIGHT, 16'd0);
		send_sample_set(0, 100, 200, 300, 400, 500, 500, 30);
		wait_drained();
		// a write to the unused index must leave the threshold alone
		write_reg(CFG_SPARE, 16'h0123);
		write_reg(s2wp_pkg::CFG_ROOM_WIDTH, 16'd3000);
		write_reg(s2wp_pkg::CFG_ROOM_HEIGHT, 16'd3000);
		send_sample_set(512, 512, 512, 512, 512, 1500, 1500, 10);
		wait_drained();
		// upper bits of the write data are dropped for the threshold
		write_reg(s2wp_pkg::CFG_THRESHOLD, 16'hF123);
		send_sample_set(290, 291, 292, 0, 4095, 1250, 1000, 270);
	endtask

	// random sample sets under several register settings
	task automatic test_random_phases();
		int p;
		int n;
		for (p = 0; p < 6; p++) begin
			wait_drained();
			case (p)
				0, 5: begin
					write_reg(s2wp_pkg::CFG_THRESHOLD, 16'(s2wp_pkg::THRESHOLD_RESET));
					write_reg(s2wp_pkg::CFG_ROOM_WIDTH, s2wp_pkg::ROOM_WIDTH_RESET);
					write_reg(s2wp_pkg::CFG_ROOM_HEIGHT, s2wp_pkg::ROOM_HEIGHT_RESET);
				end
				1: begin
					write_reg(s2wp_pkg::CFG_THRESHOLD, 16'd4095);
					write_reg(s2wp_pkg::CFG_ROOM_WIDTH, 16'd65535);
					write_reg(s2wp_pkg::CFG_ROOM_HEIGHT, 16'd65535);
				end
				2: begin
					write_reg(s2wp_pkg::CFG_THRESHOLD, 16'($urandom_range(300, 2500)));
					write_reg(s2wp_pkg::CFG_ROOM_WIDTH, 16'($urandom_range(1, 65535)));
					write_reg(s2wp_pkg::CFG_ROOM_HEIGHT, 16'($urandom_range(1, 65535)));
				end
				3: begin
					write_reg(s2wp_pkg::CFG_THRESHOLD, 16'd1);
					write_reg(s2wp_pkg::CFG_ROOM_WIDTH, 16'd1);
					write_reg(s2wp_pkg::CFG_ROOM_HEIGHT, 16'd1);
				end
				default: begin
					write_reg(s2wp_pkg::CFG_THRESHOLD, 16'($urandom_range(0, 65535)));
					write_reg(s2wp_pkg::CFG_ROOM_WIDTH, 16'($urandom_range(0, 65535)));
					write_reg(s2wp_pkg::CFG_ROOM_HEIGHT, 16'($urandom_range(0, 65535)));
				end
			endcase
			for (n = 0; n < PHASE_ITEMS; n++) begin
				// halfway through, hold off until the pipeline is empty
				if (n == PHASE_ITEMS / 2)
					wait_drained();
				send_sample_set(pick_sample(), pick_sample(), pick_sample(), pick_sample(),
					pick_sample(), pick_coord(room_x_max), pick_coord(room_y_max),
					pick_heading());
			end
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_geometry();
		test_register_extremes();
		test_random_phases();
		wait_drained();
		if (failures == 0 && expected_points.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
